// ----- hdl/lsds_pkg.sv -----
// ----------------------------------------------------------------------------
// lsds_pkg
// Shared types and constants for the LIFO stack with search and delete.
// ----------------------------------------------------------------------------
package lsds_pkg;

  // Default number of stack entries.
  localparam int unsigned DefaultDepth = 8;

  // Width of one stored word.
  localparam int unsigned DataW = 32;

  // Fixed widths of the result fields.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned MidxW   = 3;
  localparam int unsigned CountW  = 4;

  // Operation codes carried by an input item.
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_DEL   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  // Status codes carried by a result item.
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Per-cell update command from the top level.
  typedef struct packed {
    logic wr;   // load the pushed word into this cell
    logic del;  // delete in progress: cells at or above the match take the upper word
  } cell_ctrl_t;

endpackage

// ----- hdl/lsds_cell.sv -----
// ----------------------------------------------------------------------------
// lsds_cell
// One stack entry: holds a word, compares it against the search value and
// forwards the first-match chain to the cell above.
// ----------------------------------------------------------------------------
module lsds_cell (
  input  logic                        clk_i,
  input  logic                        cmp_en_i,
  input  logic [lsds_pkg::DataW-1:0]  cmp_data_i,
  input  logic                        in_range_i,
  input  lsds_pkg::cell_ctrl_t        ctrl_i,
  input  logic [lsds_pkg::DataW-1:0]  wr_data_i,
  input  logic [lsds_pkg::DataW-1:0]  above_i,
  input  logic                        hit_below_i,
  output logic [lsds_pkg::DataW-1:0]  entry_o,
  output logic                        hit_upto_o,
  output logic                        first_hit_o
);
  import lsds_pkg::*;

  logic [DataW-1:0] entry_q;
  logic             match_q;

  // Compare the held word when an item is taken; only occupied cells count.
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      match_q <= in_range_i && (entry_q == cmp_data_i);
    end
  end

  // A match here or in any cell below makes this cell take its upper neighbor.
  assign hit_upto_o  = hit_below_i | match_q;
  assign first_hit_o = match_q & ~hit_below_i;

  // Entry update: push write, or shift down during a delete.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      entry_q <= wr_data_i;
    end else if (ctrl_i.del && hit_upto_o) begin
      entry_q <= above_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- hdl/lifo_stack_search_delete_top.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_search_delete_top
// Bounded LIFO stack of signed words with push, pop, delete-first-match and
// clear, built as a row of entry cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item has a
// compare cycle and an update cycle: in the compare cycle every cell compares
// its word with data_in_i, in the update cycle the first match is resolved
// along the cell chain and the stack is updated. busy is high during the
// update cycle, so no new item is taken until it ends. The result item
// appears in the cycle after the update cycle, for exactly one cycle with
// done_o high; it must be captured then, as it cannot be held off. Words are
// only read once they have been written; clear just resets the count.
module lifo_stack_search_delete_top #(
  parameter int unsigned DEPTH = lsds_pkg::DefaultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lsds_pkg::ModeW-1:0]    mode_i,
  input  logic signed [lsds_pkg::DataW-1:0] data_in_i,
  output logic                          done_o,
  output logic [lsds_pkg::StatusW-1:0]  status_o,
  output logic signed [lsds_pkg::DataW-1:0] data_out_o,
  output logic [lsds_pkg::MidxW-1:0]    match_index_o,
  output logic [lsds_pkg::CountW-1:0]   count_after_o
);
  import lsds_pkg::*;

  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              accept;
  logic              busy_q;
  logic [OccW-1:0]   occ_q, occ_d;
  mode_e             mode_q;
  logic [DataW-1:0]  data_q;

  logic [DataW-1:0]  entry   [DEPTH];
  logic [DEPTH-1:0]  in_range;
  logic [DEPTH-1:0]  hit_upto;
  logic [DEPTH-1:0]  first_hit;
  cell_ctrl_t        ctrl    [DEPTH];

  logic              full, empty, any_hit;
  logic [IdxW-1:0]   hit_idx;
  logic [IdxW-1:0]   top_idx;
  status_e           status_d;
  logic [DataW-1:0]  dout_d;

  logic              done_q;
  status_e           status_q;
  logic [DataW-1:0]  dout_q;
  logic [MidxW-1:0]  midx_q;
  logic [CountW-1:0] count_q;

  assign accept = start & ~busy_q;
  assign busy   = busy_q;

  // Control: busy is raised after each accepted item, then the result strobe follows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      occ_q  <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) begin
        occ_q <= occ_d;
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      data_q <= data_in_i;
    end
  end

  // Occupied-cell mask for the compare cycle.
  always_comb begin
    for (int unsigned i = 0; i < DEPTH; i++) begin
      in_range[i] = (OccW'(i) < occ_q);
    end
  end

  // Row of entry cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] above;
    logic             hit_below;

    if (g == DEPTH - 1) begin : g_top
      assign above = entry[g];
    end else begin : g_mid
      assign above = entry[g+1];
    end

    if (g == 0) begin : g_bot
      assign hit_below = 1'b0;
    end else begin : g_up
      assign hit_below = hit_upto[g-1];
    end

    assign ctrl[g].wr  = busy_q && (mode_q == MODE_PUSH) && (occ_q == OccW'(g));
    assign ctrl[g].del = busy_q && (mode_q == MODE_DEL);

    lsds_cell u_cell (
      .clk_i       (clk_i),
      .cmp_en_i    (accept),
      .cmp_data_i  (data_in_i),
      .in_range_i  (in_range[g]),
      .ctrl_i      (ctrl[g]),
      .wr_data_i   (data_q),
      .above_i     (above),
      .hit_below_i (hit_below),
      .entry_o     (entry[g]),
      .hit_upto_o  (hit_upto[g]),
      .first_hit_o (first_hit[g])
    );
  end

  // Binary index of the first match.
  always_comb begin
    hit_idx = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | ({IdxW{first_hit[i]}} & IdxW'(i));
    end
  end

  assign full    = (occ_q == OccW'(DEPTH));
  assign empty   = (occ_q == '0);
  assign any_hit = hit_upto[DEPTH-1];
  assign top_idx = IdxW'(occ_q - OccW'(1));

  // Result and next occupancy for the item in its update cycle.
  always_comb begin
    status_d = ST_OK;
    dout_d   = '0;
    occ_d    = occ_q;
    case (mode_q)
      MODE_PUSH: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          occ_d = occ_q + OccW'(1);
        end
      end
      MODE_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
          dout_d   = '1;
        end else begin
          occ_d  = occ_q - OccW'(1);
          dout_d = entry[top_idx];
        end
      end
      MODE_DEL: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!any_hit) begin
          status_d = ST_NOTFOUND;
        end else begin
          occ_d = occ_q - OccW'(1);
        end
      end
      MODE_CLEAR: begin
        occ_d = '0;
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q <= status_d;
      dout_q   <= dout_d;
      midx_q   <= (mode_q == MODE_DEL && status_d == ST_OK) ? MidxW'(hit_idx) : '0;
      count_q  <= CountW'(occ_d);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign data_out_o    = dout_q;
  assign match_index_o = midx_q;
  assign count_after_o = count_q;

  // A result always follows an update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q))
    else $error("result strobe without an update cycle");

  // The update cycle never repeats back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("busy held for more than one cycle");

  // Occupancy never exceeds the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(DEPTH))
    else $error("occupancy above depth");

  // Overflow is only reported with a full stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OVERFLOW) |-> $past(full, 2) && $stable(occ_q))
    else $error("overflow reported on a stack that was not full");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lifo_stack_search_delete_top. A driver presents
// push, pop, delete and clear items with random idle gaps; a stack model
// inside the bench predicts each result, and a monitor compares every done
// strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsds_pkg::*;

  localparam int unsigned Depth      = DefaultDepth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 550;
  localparam int unsigned MaxReports = 10;

  // One stimulus item plus its idle gap and an optional hold until drained.
  typedef struct {
    mode_e                     mode;
    logic signed [DataW-1:0]   value;
    int unsigned               gap;
    bit                        drain;
  } stack_op_t;

  // One result item as seen on the output ports.
  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   data;
    logic [MidxW-1:0]          midx;
    logic [CountW-1:0]         count;
  } stack_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  mode_e                     mode_q = MODE_PUSH;
  logic signed [DataW-1:0]   data_q = '0;
  logic                      busy;
  logic                      done_o;
  logic [StatusW-1:0]        status_o;
  logic signed [DataW-1:0]   data_out_o;
  logic [MidxW-1:0]          match_index_o;
  logic [CountW-1:0]         count_after_o;

  stack_op_t                 pending_ops[$];
  stack_result_t             expected_results[$];

  // Predicted stack contents.
  logic signed [DataW-1:0]   stack_words[Depth];
  int unsigned               stack_occ = 0;

  int unsigned               idle_left = 0;
  int unsigned               mismatches = 0;
  int unsigned               cycle_cnt = 0;
  int unsigned               mode_seen[4] = '{default: 0};
  int unsigned               status_seen[4] = '{default: 0};

  lifo_stack_search_delete_top #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_q),
    .data_in_i     (data_q),
    .done_o        (done_o),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .match_index_o (match_index_o),
    .count_after_o (count_after_o)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Applies one operation to the predicted stack and returns its result.
  function automatic stack_result_t stack_apply(mode_e mode, logic signed [DataW-1:0] value);
    stack_result_t res;
    bit            found;
    int unsigned   hit_idx;
    res     = '{status: ST_OK, data: '0, midx: '0, count: '0};
    found   = 1'b0;
    hit_idx = 0;
    case (mode)
      MODE_PUSH: begin
        if (stack_occ >= Depth) begin
          res.status = ST_OVERFLOW;
        end else begin
          stack_words[stack_occ] = value;
          stack_occ++;
        end
      end
      MODE_POP: begin
        if (stack_occ == 0) begin
          res.status = ST_EMPTY;
          res.data   = -1;
        end else begin
          stack_occ--;
          res.data = stack_words[stack_occ];
        end
      end
      MODE_DEL: begin
        if (stack_occ == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Only the lowest matching entry is removed.
          for (int i = 0; i < Depth; i++) begin
            if (!found && i < stack_occ && stack_words[i] == value) begin
              found   = 1'b1;
              hit_idx = i;
            end
          end
          if (!found) begin
            res.status = ST_NOTFOUND;
          end else begin
            for (int i = hit_idx; i + 1 < stack_occ; i++) begin
              stack_words[i] = stack_words[i+1];
            end
            stack_occ--;
            res.midx = hit_idx[MidxW-1:0];
          end
        end
      end
      default: begin
        stack_occ = 0;
      end
    endcase
    res.count = stack_occ[CountW-1:0];
    return res;
  endfunction

  // Small values in four of ten picks so that deletes find matches, plus extremes and noise.
  function automatic logic signed [DataW-1:0] pick_value();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $signed($urandom_range(0, 6)) - 1;
      4:          v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // Driver: presents queued items and records a prediction for each one taken.
  always @(posedge clk_i) begin
    stack_op_t nxt;
    logic      next_start;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_results.push_back(stack_apply(mode_q, data_q));
        mode_seen[mode_q]++;
        next_start = 1'b0;
        idle_left  = (pending_ops.size() > 0) ? pending_ops[0].gap : 0;
      end
      if (!next_start && pending_ops.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (!pending_ops[0].drain || expected_results.size() == 0) begin
          nxt = pending_ops.pop_front();
          mode_q     <= nxt.mode;
          data_q     <= nxt.value;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every done strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_ni && done_o) begin
      got = '{status: status_e'(status_o), data: data_out_o,
              midx: match_index_o, count: count_after_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("ERROR: unexpected result status=%0d data=%0d idx=%0d count=%0d",
                   got.status, got.data, got.midx, got.count);
        end
      end else begin
        want = expected_results.pop_front();
        status_seen[want.status]++;
        if (got != want) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("ERROR: status exp %s got %0d | data exp %0d got %0d",
                     want.status.name(), got.status, want.data, got.data);
            $display("       index exp %0d got %0d | count exp %0d got %0d",
                     want.midx, got.midx, want.count, got.count);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("ERROR: timeout after %0d cycles", cycle_cnt);
    $display("testbench: FAIL");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    stack_op_t op;
    bit        fill_phase;
    int unsigned roll;

    // Directed items: empty-stack cases, extremes, full stack and overflow,
    // first of several matches, no match, top and bottom removal, clear.
    pending_ops.push_back('{MODE_POP,   32'sd0,            0, 1'b0});
    pending_ops.push_back('{MODE_DEL,   32'sd5,            1, 1'b0});
    pending_ops.push_back('{MODE_CLEAR, 32'sh7fff_ffff,    0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sh8000_0000,    0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sh7fff_ffff,    2, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sd0,            0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  -32'sd1,           0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sh7fff_ffff,    3, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sh5555_5555,    0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'shaaaa_aaaa,    0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sh1234_5678,    0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sd1,            0, 1'b0});
    pending_ops.push_back('{MODE_DEL,   32'sh7fff_ffff,    0, 1'b1});
    pending_ops.push_back('{MODE_DEL,   32'sh1357_9bdf,    0, 1'b0});
    pending_ops.push_back('{MODE_DEL,   32'sh1234_5678,    1, 1'b0});
    pending_ops.push_back('{MODE_DEL,   32'sh8000_0000,    0, 1'b0});
    pending_ops.push_back('{MODE_POP,   32'sd0,            0, 1'b0});
    pending_ops.push_back('{MODE_DEL,   -32'sd1,           0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sd3,            0, 1'b0});
    pending_ops.push_back('{MODE_CLEAR, 32'sd0,            0, 1'b0});
    pending_ops.push_back('{MODE_POP,   32'sd0,            0, 1'b0});
    pending_ops.push_back('{MODE_PUSH,  32'sd7,            0, 1'b1});
    pending_ops.push_back('{MODE_POP,   32'sd0,            0, 1'b0});

    // Random items in alternating fill and drain phases, with some stretches
    // that have no idle gaps at all.
    for (int n = 0; n < NumRandom; n++) begin
      fill_phase = ((n / 30) % 2) == 0;
      roll       = $urandom_range(0, 99);
      if (roll < 3) begin
        op.mode = MODE_CLEAR;
      end else if (roll < (fill_phase ? 63 : 28)) begin
        op.mode = MODE_PUSH;
      end else if (roll < (fill_phase ? 80 : 63)) begin
        op.mode = MODE_POP;
      end else begin
        op.mode = MODE_DEL;
      end
      op.value = pick_value();
      op.gap   = (((n / 40) % 3) == 0) ? 0 : $urandom_range(0, 3);
      op.drain = ($urandom_range(0, 49) == 0);
      pending_ops.push_back(op);
    end

    // Hold reset from the start, then release it at a clock edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until all items are taken and all results are in, then let the
    // pipeline settle so a stray result would still be caught.
    do begin
      @(posedge clk_i);
    end while (pending_ops.size() != 0 || start || expected_results.size() != 0);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d push, %0d pop, %0d delete and %0d clear items.",
             mode_seen[MODE_PUSH], mode_seen[MODE_POP], mode_seen[MODE_DEL],
             mode_seen[MODE_CLEAR]);
    $display("Results: %0d ok, %0d overflow, %0d empty, %0d not found; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND], mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
